@@ hw/rtl/mmc_pkg.sv @@
// mmc_pkg: shared widths, register map, payload and configuration types
// for the magnetometer min/max calibrator. Depends on nothing.

package mmc_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int SPAN_W          = SAMPLE_W;
    localparam int SUM_W           = SPAN_W + 2;
    localparam int SCALE_W         = 16;
    localparam int RADIUS_W        = 15;
    localparam int SCALE_FRAC_BITS = 14;
    localparam int NUM_AXES        = 3;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // register indexes, byte address = 4 * index
    localparam logic [REG_IDX_W-1:0] REG_CAL_ENABLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FB_OFF_X   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FB_OFF_Y   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FB_OFF_Z   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FB_SCALE_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FB_SCALE_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FB_SCALE_Z = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MIN_RADIUS = 3'd7;

    localparam logic [SCALE_W-1:0]  FB_SCALE_RST   = 16'd16384;
    localparam logic [RADIUS_W-1:0] MIN_RADIUS_RST = 15'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mag_x;
        logic signed [SAMPLE_W-1:0] mag_y;
        logic signed [SAMPLE_W-1:0] mag_z;
        logic                       has_sample;
        logic                       finish;
    } t_in_item;

    // hard_x/y/z: hard-iron offsets, Q12.4
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] hard_x;
        logic signed [SAMPLE_W-1:0] hard_y;
        logic signed [SAMPLE_W-1:0] hard_z;
        logic        [SCALE_W-1:0]  scale_x;
        logic        [SCALE_W-1:0]  scale_y;
        logic        [SCALE_W-1:0]  scale_z;
        logic                       calibrated;
    } t_out_item;

    typedef struct packed {
        logic                                cal_enable;
        logic [NUM_AXES-1:0][SAMPLE_W-1:0]   fb_offset;
        logic [NUM_AXES-1:0][SCALE_W-1:0]    fb_scale;
        logic [RADIUS_W-1:0]                 min_radius;
    } t_cfg;

endpackage

@@ hw/rtl/mmc_div.sv @@
// mmc_div: radix-2 restoring divider, one quotient bit per cycle,
// quotient saturated to QUO_W bits. Depends on nothing.

module mmc_div #(
    parameter int DVD_W = 32,
    parameter int DIV_W = 18,
    parameter int QUO_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [QUO_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd, n_dvd;   // dividend in, quotient bits shift in at the bottom
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;

    logic [DIV_W:0] w_trial;
    logic [DIV_W:0] w_diff;
    logic           w_ge;
    logic           w_sat;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign n_rem   = w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
    assign n_dvd   = {r_dvd[DVD_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DVD_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (o_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign w_sat      = |r_dvd[DVD_W-1:QUO_W];
    assign o_quotient = w_sat ? {QUO_W{1'b1}} : r_dvd[QUO_W-1:0];

endmodule

@@ hw/rtl/mmc_lane.sv @@
// mmc_lane: one axis - running min/max tracker, offset and span, and a
// serial divider for the scale. Depends on mmc_pkg and mmc_div.

module mmc_lane #(
    parameter int SCALE_FRAC_BITS = mmc_pkg::SCALE_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_upd,
    input  logic signed [mmc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_clr,
    input  logic                                i_start,
    input  logic [mmc_pkg::SUM_W-1:0]           i_sum,
    output logic [mmc_pkg::SPAN_W-1:0]          o_span,
    output logic signed [mmc_pkg::SAMPLE_W-1:0] o_offset,
    output logic [mmc_pkg::SCALE_W-1:0]         o_scale,
    output logic                                o_busy
);
    localparam int W     = mmc_pkg::SAMPLE_W;
    localparam int DVD_W = mmc_pkg::SUM_W + SCALE_FRAC_BITS;

    logic signed [W-1:0] r_low, r_high;
    logic signed [W-1:0] r_offset;

    logic [W:0]                 w_diff;
    logic [W:0]                 w_pair;
    logic [mmc_pkg::SUM_W-1:0]  w_divisor;
    logic [DVD_W-1:0]           w_dividend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_low  <= {1'b0, {(W-1){1'b1}}};
            r_high <= {1'b1, {(W-1){1'b0}}};
        end else if (i_upd) begin
            if (i_sample < r_low) begin
                r_low <= i_sample;
            end
            if (i_sample > r_high) begin
                r_high <= i_sample;
            end
        end
    end

    // high >= low whenever a sample was seen, so the span fits W unsigned bits
    assign w_diff = {r_high[W-1], r_high} - {r_low[W-1], r_low};
    assign o_span = w_diff[W-1:0];

    // floor((low + high) / 2) is an arithmetic shift of the W+1 bit sum
    assign w_pair = {r_high[W-1], r_high} + {r_low[W-1], r_low};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_offset <= w_pair[W:1];
        end
    end

    assign o_offset   = r_offset;
    assign w_divisor  = {2'b00, o_span} + {1'b0, o_span, 1'b0};
    assign w_dividend = {i_sum, {SCALE_FRAC_BITS{1'b0}}};

    mmc_div #(
        .DVD_W (DVD_W),
        .DIV_W (mmc_pkg::SUM_W),
        .QUO_W (mmc_pkg::SCALE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (o_busy),
        .o_quotient (o_scale)
    );

endmodule

@@ hw/rtl/mmc_merge.sv @@
// mmc_merge: combines the three lanes - spread checks, span sum, and the
// choice between computed and fallback values. Depends on mmc_pkg.

module mmc_merge (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    i_check,
    input  logic                                                    i_seen,
    input  mmc_pkg::t_cfg                                           i_cfg,
    input  logic [mmc_pkg::NUM_AXES-1:0][mmc_pkg::SPAN_W-1:0]       i_span,
    input  logic [mmc_pkg::NUM_AXES-1:0][mmc_pkg::SAMPLE_W-1:0]     i_offset,
    input  logic [mmc_pkg::NUM_AXES-1:0][mmc_pkg::SCALE_W-1:0]      i_scale,
    output logic                                                    o_ok,
    output logic [mmc_pkg::SUM_W-1:0]                               o_sum,
    output mmc_pkg::t_out_item                                      o_result
);
    localparam int N = mmc_pkg::NUM_AXES;

    logic [mmc_pkg::SPAN_W-1:0] w_thr2;
    logic [mmc_pkg::SUM_W-1:0]  w_thr6;
    logic [N-1:0]               w_wide;
    logic                       r_ok;

    assign w_thr2 = {i_cfg.min_radius, 1'b0};
    assign w_thr6 = {1'b0, i_cfg.min_radius, 2'b00} + {2'b00, i_cfg.min_radius, 1'b0};
    assign o_sum  = {2'b00, i_span[0]} + {2'b00, i_span[1]} + {2'b00, i_span[2]};

    always_comb begin
        for (int a = 0; a < N; a++) begin
            w_wide[a] = (i_span[a] > w_thr2);
        end
    end

    assign o_ok = i_cfg.cal_enable && i_seen && (&w_wide) && (o_sum > w_thr6);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= 1'b0;
        end else if (i_check) begin
            r_ok <= o_ok;
        end
    end

    always_comb begin
        if (r_ok) begin
            o_result.hard_x  = i_offset[0];
            o_result.hard_y  = i_offset[1];
            o_result.hard_z  = i_offset[2];
            o_result.scale_x = i_scale[0];
            o_result.scale_y = i_scale[1];
            o_result.scale_z = i_scale[2];
        end else begin
            o_result.hard_x  = i_cfg.fb_offset[0];
            o_result.hard_y  = i_cfg.fb_offset[1];
            o_result.hard_z  = i_cfg.fb_offset[2];
            o_result.scale_x = i_cfg.fb_scale[0];
            o_result.scale_y = i_cfg.fb_scale[1];
            o_result.scale_z = i_cfg.fb_scale[2];
        end
        o_result.calibrated = r_ok;
    end

endmodule

@@ hw/rtl/mag_minmax_calibrator_top.sv @@
// mag_minmax_calibrator_top: three axis lanes and a merge stage; depends on mmc_pkg,
// mmc_lane, mmc_div, mmc_merge. Sample items are taken one per cycle and give no result.
// Finish item, calibrated: CHECK judges the window, DIV runs the divider steps and waits
// to see them end, DONE loads the result. Fallback skips DIV and goes from CHECK to DONE.
// Input is held off until the load; a full output register stretches it. Reset (sync,
// low): trackers empty, defaults.

module mag_minmax_calibrator_top #(
    parameter int SCALE_FRAC_BITS = mmc_pkg::SCALE_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input item channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mmc_pkg::t_in_item                  i_in_data,
    // result item channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mmc_pkg::t_out_item                 o_out_data,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mmc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mmc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mmc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    localparam int N = mmc_pkg::NUM_AXES;

    // one-hot control: IDLE takes items, CHECK judges the window and, if it
    // passes, starts the lanes, DIV waits on the dividers, DONE loads the output register
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    mmc_pkg::t_cfg      r_cfg;
    mmc_pkg::t_out_item r_out;
    logic               r_out_valid;
    logic               r_seen;

    logic                         w_in_fire;
    logic                         w_upd;
    logic                         w_check;
    logic                         w_start;
    logic                         w_load;
    logic                         w_ok;
    logic                         w_cfg_wr;
    logic [mmc_pkg::REG_IDX_W-1:0] w_idx;
    logic [mmc_pkg::SUM_W-1:0]    w_sum;
    logic [N-1:0]                 w_busy;
    mmc_pkg::t_out_item           w_result;

    logic signed [mmc_pkg::SAMPLE_W-1:0]           w_sample [N];
    logic [N-1:0][mmc_pkg::SPAN_W-1:0]             w_span;
    logic [N-1:0][mmc_pkg::SAMPLE_W-1:0]           w_offset;
    logic [N-1:0][mmc_pkg::SCALE_W-1:0]            w_scale;

    // ---------------------------------------------------------------
    // configuration registers, APB writes complete in the access phase
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_idx    = paddr[mmc_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal_enable <= 1'b1;
            r_cfg.fb_offset  <= '0;
            r_cfg.fb_scale   <= {N{mmc_pkg::FB_SCALE_RST}};
            r_cfg.min_radius <= mmc_pkg::MIN_RADIUS_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                mmc_pkg::REG_CAL_ENABLE: r_cfg.cal_enable   <= pwdata[0];
                mmc_pkg::REG_FB_OFF_X:   r_cfg.fb_offset[0] <= pwdata[15:0];
                mmc_pkg::REG_FB_OFF_Y:   r_cfg.fb_offset[1] <= pwdata[15:0];
                mmc_pkg::REG_FB_OFF_Z:   r_cfg.fb_offset[2] <= pwdata[15:0];
                mmc_pkg::REG_FB_SCALE_X: r_cfg.fb_scale[0]  <= pwdata[15:0];
                mmc_pkg::REG_FB_SCALE_Y: r_cfg.fb_scale[1]  <= pwdata[15:0];
                mmc_pkg::REG_FB_SCALE_Z: r_cfg.fb_scale[2]  <= pwdata[15:0];
                mmc_pkg::REG_MIN_RADIUS: r_cfg.min_radius   <= pwdata[14:0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            mmc_pkg::REG_CAL_ENABLE: prdata[0]    = r_cfg.cal_enable;
            mmc_pkg::REG_FB_OFF_X:   prdata[15:0] = r_cfg.fb_offset[0];
            mmc_pkg::REG_FB_OFF_Y:   prdata[15:0] = r_cfg.fb_offset[1];
            mmc_pkg::REG_FB_OFF_Z:   prdata[15:0] = r_cfg.fb_offset[2];
            mmc_pkg::REG_FB_SCALE_X: prdata[15:0] = r_cfg.fb_scale[0];
            mmc_pkg::REG_FB_SCALE_Y: prdata[15:0] = r_cfg.fb_scale[1];
            mmc_pkg::REG_FB_SCALE_Z: prdata[15:0] = r_cfg.fb_scale[2];
            mmc_pkg::REG_MIN_RADIUS: prdata[14:0] = r_cfg.min_radius;
        endcase
    end

    // ---------------------------------------------------------------
    // control
    // ---------------------------------------------------------------
    // items are taken in IDLE even while a result still waits downstream
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_upd      = w_in_fire && i_in_data.has_sample;
    assign w_check    = (r_state == S_CHECK);
    assign w_start    = w_check && w_ok;
    // result loads once the output register is free or being drained
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_fire && i_in_data.finish) n_state = S_CHECK;
            S_CHECK: n_state = w_ok ? S_DIV : S_DONE;
            S_DIV:   if (w_busy == '0) n_state = S_DONE;
            S_DONE:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // the finish item's own sample lands at the accept edge, before CHECK
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_check) begin
            r_seen <= 1'b0;
        end else if (w_upd) begin
            r_seen <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // axis lanes
    // ---------------------------------------------------------------
    assign w_sample[0] = i_in_data.mag_x;
    assign w_sample[1] = i_in_data.mag_y;
    assign w_sample[2] = i_in_data.mag_z;

    for (genvar g = 0; g < N; g++) begin : g_lane
        mmc_lane #(
            .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_upd    (w_upd),
            .i_sample (w_sample[g]),
            .i_clr    (w_check),
            .i_start  (w_start),
            .i_sum    (w_sum),
            .o_span   (w_span[g]),
            .o_offset (w_offset[g]),
            .o_scale  (w_scale[g]),
            .o_busy   (w_busy[g])
        );
    end

    mmc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_check  (w_check),
        .i_seen   (r_seen),
        .i_cfg    (r_cfg),
        .i_span   (w_span),
        .i_offset (w_offset),
        .i_scale  (w_scale),
        .o_ok     (w_ok),
        .o_sum    (w_sum),
        .o_result (w_result)
    );

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_finish_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in_data.finish) |=> (r_state == S_CHECK))
        else $error("finish item did not enter the check cycle");

    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_busy[0] == w_busy[1]) && (w_busy[1] == w_busy[2]))
        else $error("lane dividers out of step");

    a_cal_scale_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.calibrated) |->
        (o_out_data.scale_x != '0 && o_out_data.scale_y != '0 && o_out_data.scale_z != '0))
        else $error("calibrated item carries a zero scale");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the load state");

endmodule

@@ tb/tb_mag_minmax_calibrator_top.sv @@
`timescale 1ns / 100ps
// tb_mag_minmax_calibrator_top: self-checking testbench for the magnetometer min/max calibrator.
// Depends on mmc_pkg and mag_minmax_calibrator_top.

module tb_mag_minmax_calibrator_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 48;     // check + divider + load, with margin
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_ITEMS   = 85;     // counted items per long random phase

    // Scoreboard: holds its own copy of the registers and the min/max trackers,
    // predicts each result at input accept and checks results in order.
    class calib_scoreboard;
        mmc_pkg::t_out_item                   expected_cal_q[$];
        logic signed [mmc_pkg::SAMPLE_W-1:0] low_r[mmc_pkg::NUM_AXES];
        logic signed [mmc_pkg::SAMPLE_W-1:0] high_r[mmc_pkg::NUM_AXES];
        bit                                  seen_r;
        bit                                  enable_r;
        logic signed [mmc_pkg::SAMPLE_W-1:0] fb_off_r[mmc_pkg::NUM_AXES];
        logic [mmc_pkg::SCALE_W-1:0]         fb_scale_r[mmc_pkg::NUM_AXES];
        logic [mmc_pkg::RADIUS_W-1:0]        radius_r;
        int errors, n_inputs, n_results, n_calibrated, n_saturated, n_fallback;

        function new();
            enable_r = 1'b1;
            radius_r = mmc_pkg::MIN_RADIUS_RST;
            for (int a = 0; a < mmc_pkg::NUM_AXES; a++) begin
                fb_off_r[a]   = '0;
                fb_scale_r[a] = mmc_pkg::FB_SCALE_RST;
            end
            clear_trackers();
        endfunction

        function void clear_trackers();
            for (int a = 0; a < mmc_pkg::NUM_AXES; a++) begin
                low_r[a]  = 16'sh7FFF;
                high_r[a] = 16'sh8000;
            end
            seen_r = 1'b0;
        endfunction

        function int pending();
            return expected_cal_q.size();
        endfunction

        // keeps only the register's width, like the block
        function void write_reg(logic [mmc_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                mmc_pkg::REG_CAL_ENABLE: enable_r      = val[0];
                mmc_pkg::REG_FB_OFF_X:   fb_off_r[0]   = val[15:0];
                mmc_pkg::REG_FB_OFF_Y:   fb_off_r[1]   = val[15:0];
                mmc_pkg::REG_FB_OFF_Z:   fb_off_r[2]   = val[15:0];
                mmc_pkg::REG_FB_SCALE_X: fb_scale_r[0] = val[15:0];
                mmc_pkg::REG_FB_SCALE_Y: fb_scale_r[1] = val[15:0];
                mmc_pkg::REG_FB_SCALE_Z: fb_scale_r[2] = val[15:0];
                mmc_pkg::REG_MIN_RADIUS: radius_r      = val[14:0];
                default: ;
            endcase
        endfunction

        function void take_item(mmc_pkg::t_in_item it);
            logic signed [mmc_pkg::SAMPLE_W-1:0] smp[mmc_pkg::NUM_AXES];
            int                 span[mmc_pkg::NUM_AXES];
            int                 thr, span_sum, mid;
            longint             quot;
            bit                 good;
            mmc_pkg::t_out_item res;
            n_inputs++;
            smp[0] = it.mag_x;
            smp[1] = it.mag_y;
            smp[2] = it.mag_z;
            if (it.has_sample) begin
                for (int a = 0; a < mmc_pkg::NUM_AXES; a++) begin
                    if (smp[a] < low_r[a])  low_r[a]  = smp[a];
                    if (smp[a] > high_r[a]) high_r[a] = smp[a];
                end
                seen_r = 1'b1;
            end
            if (!it.finish) return;

            thr      = int'(radius_r);
            good     = enable_r && seen_r;
            span_sum = 0;
            for (int a = 0; a < mmc_pkg::NUM_AXES; a++) begin
                span[a]   = int'(high_r[a]) - int'(low_r[a]);
                span_sum += span[a];
                if (span[a] <= 2 * thr) good = 1'b0;
            end
            if (span_sum <= 6 * thr) good = 1'b0;

            if (good) begin
                logic signed [mmc_pkg::SAMPLE_W-1:0] off[mmc_pkg::NUM_AXES];
                logic [mmc_pkg::SCALE_W-1:0]         scl[mmc_pkg::NUM_AXES];
                for (int a = 0; a < mmc_pkg::NUM_AXES; a++) begin
                    mid    = (int'(low_r[a]) + int'(high_r[a])) >>> 1;   // floor
                    off[a] = mid[15:0];
                    quot   = (longint'(span_sum) << mmc_pkg::SCALE_FRAC_BITS)
                             / (3 * longint'(span[a]));
                    if (quot > 65535) begin
                        quot = 65535;
                        n_saturated++;
                    end
                    scl[a] = quot[15:0];
                end
                res = '{off[0], off[1], off[2], scl[0], scl[1], scl[2], 1'b1};
                n_calibrated++;
            end else begin
                res = '{fb_off_r[0], fb_off_r[1], fb_off_r[2],
                        fb_scale_r[0], fb_scale_r[1], fb_scale_r[2], 1'b0};
                n_fallback++;
            end
            expected_cal_q.push_back(res);
            clear_trackers();
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        task check_result(mmc_pkg::t_out_item got);
            mmc_pkg::t_out_item want;
            n_results++;
            if (expected_cal_q.size() == 0) begin
                report_mismatch("result item with no expectation pending");
                return;
            end
            want = expected_cal_q.pop_front();
            if (got.hard_x !== want.hard_x)
                report_mismatch($sformatf("hard_x got %0d want %0d", got.hard_x, want.hard_x));
            if (got.hard_y !== want.hard_y)
                report_mismatch($sformatf("hard_y got %0d want %0d", got.hard_y, want.hard_y));
            if (got.hard_z !== want.hard_z)
                report_mismatch($sformatf("hard_z got %0d want %0d", got.hard_z, want.hard_z));
            if (got.scale_x !== want.scale_x)
                report_mismatch($sformatf("scale_x got %0d want %0d", got.scale_x, want.scale_x));
            if (got.scale_y !== want.scale_y)
                report_mismatch($sformatf("scale_y got %0d want %0d", got.scale_y, want.scale_y));
            if (got.scale_z !== want.scale_z)
                report_mismatch($sformatf("scale_z got %0d want %0d", got.scale_z, want.scale_z));
            if (got.calibrated !== want.calibrated)
                report_mismatch($sformatf("calibrated got %b want %b",
                                          got.calibrated, want.calibrated));
        endtask
    endclass

    // ---------------------------------------------------------------- signals
    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    mmc_pkg::t_in_item              i_in_data  = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    mmc_pkg::t_out_item             o_out_data;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [mmc_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [mmc_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [mmc_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    calib_scoreboard calib_sb = new();

    bit calm     = 1'b0;   // both sides run with no idling while set
    bit hold_req = 1'b0;   // asks the receiver for one long hold-off
    int hold_left   = 0;
    int items_sent  = 0;   // items that touch the trackers or finish a window
    int cfg_phases  = 0;
    int cycle_count = 0;

    mag_minmax_calibrator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a correct run finishes far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, calib_sb.pending());
            $display("** mag_minmax_calibrator_top: FAILED **");
            $finish;
        end
    end

    // Monitor: values seen right at the edge are the pre-edge values, the same
    // ones the block samples, so accept and predict line up with the RTL.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                calib_sb.take_item(i_in_data);
            if (o_out_valid && i_out_ready)
                calib_sb.check_result(o_out_data);
        end
    end

    // Result side: random back-pressure, a no-stall stretch while calm is set,
    // and one long hold-off counted here on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    // ---------------------------------------------------------------- drivers
    // APB write: setup, then access; the register takes it at the access edge.
    task automatic reg_write(input logic [mmc_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        calib_sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one item, with random gaps in front unless calm; returns at the accept edge.
    task automatic send_item(input mmc_pkg::t_in_item it);
        while (!calm && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (it.has_sample || it.finish) items_sent++;
    endtask

    function automatic mmc_pkg::t_in_item mk_item(int x, int y, int z, bit hs, bit fin);
        mmc_pkg::t_in_item it;
        it.mag_x      = x[15:0];
        it.mag_y      = y[15:0];
        it.mag_z      = z[15:0];
        it.has_sample = hs;
        it.finish     = fin;
        return it;
    endfunction

    task automatic send_noise();
        send_item(mk_item($urandom(), $urandom(), $urandom(), 1'b0, 1'b0));
    endtask

    // Drop valid, let every result drain, then give the divider time to go idle
    // so a register write never lands mid-calculation.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (calib_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_phases++;
    endtask

    task automatic write_random_config();
        reg_write(mmc_pkg::REG_CAL_ENABLE, 32'($urandom_range(0, 3) != 0));
        reg_write(mmc_pkg::REG_FB_OFF_X, $urandom());
        reg_write(mmc_pkg::REG_FB_OFF_Y, $urandom());
        reg_write(mmc_pkg::REG_FB_OFF_Z, $urandom());
        reg_write(mmc_pkg::REG_FB_SCALE_X, $urandom());
        reg_write(mmc_pkg::REG_FB_SCALE_Y, $urandom());
        reg_write(mmc_pkg::REG_FB_SCALE_Z, $urandom());
        reg_write(mmc_pkg::REG_MIN_RADIUS, $urandom_range(0, 40));
    endtask

    // One window: a few samples shaped per axis, then a finish item.
    // Spans are picked to hit full range, the threshold edge, full scale, or a
    // lopsided mix that drives one scale into saturation.
    task automatic send_window();
        int thr, mode, n, pick;
        int span[mmc_pkg::NUM_AXES];
        int base[mmc_pkg::NUM_AXES];
        int v[mmc_pkg::NUM_AXES];
        thr  = int'(calib_sb.radius_r);
        mode = $urandom_range(0, 9);
        n    = $urandom_range(0, 8);
        for (int a = 0; a < mmc_pkg::NUM_AXES; a++) begin
            pick = $urandom_range(0, 4);
            if (mode <= 3)      span[a] = $urandom_range(0, 65535);
            else if (mode <= 6) span[a] = 2 * thr - 1 + pick;
            else if (mode == 7) span[a] = 65535;
            else if (a == 0)    span[a] = 2 * thr + 1 + pick;
            else                span[a] = 65535 - $urandom_range(0, 100);
            if (span[a] < 0)     span[a] = 0;
            if (span[a] > 65535) span[a] = 65535;
            base[a] = -32768 + int'($urandom_range(0, 65535 - span[a]));
        end
        for (int k = 0; k <= n; k++) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            for (int a = 0; a < mmc_pkg::NUM_AXES; a++) begin
                if (k == 0)      v[a] = base[a];
                else if (k == 1) v[a] = base[a] + span[a];
                else             v[a] = base[a] + int'($urandom_range(0, span[a]));
            end
            if (k < n)
                send_item(mk_item(v[0], v[1], v[2], 1'b1, 1'b0));
            else
                send_item(mk_item(v[0], v[1], v[2], 1'($urandom_range(0, 1)), 1'b1));
        end
    endtask

    task automatic random_phase(int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal) send_window();
    endtask

    // ---------------------------------------------------------------- main
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: enabled, radius 2, zero offsets, unity scales
        send_item(mk_item(0, 0, 0, 1'b0, 1'b1));                  // finish, empty window
        send_item(mk_item(-32768, -32768, -32768, 1'b1, 1'b0));   // full-range corners
        send_item(mk_item(32767, 32767, 32767, 1'b1, 1'b0));
        send_item(mk_item(0, 0, 0, 1'b0, 1'b1));
        send_item(mk_item(0, -32768, -32768, 1'b1, 1'b0));        // x narrow: scale saturates
        send_item(mk_item(5, 32767, 32767, 1'b1, 1'b1));
        send_item(mk_item(-3, -3, -3, 1'b1, 1'b0));               // span exactly 2*radius
        send_item(mk_item(1, 1, 1, 1'b1, 1'b1));
        send_item(mk_item(-1, -1, -1, 1'b0, 1'b0));               // ignored: no sample, no finish
        send_item(mk_item(-3, 10, -7, 1'b1, 1'b0));               // odd negative midpoints
        send_item(mk_item(2, 15, -2, 1'b1, 1'b0));
        send_item(mk_item(0, 0, 0, 1'b0, 1'b1));
        send_item(mk_item(123, -456, 789, 1'b1, 1'b1));           // lone sample: zero spread
        settle();

        // disabled, fallbacks at extremes; upper data bits must be dropped
        reg_write(mmc_pkg::REG_CAL_ENABLE, 32'hFFFF_FFFE);
        reg_write(mmc_pkg::REG_FB_OFF_X, 32'hABCD_8000);
        reg_write(mmc_pkg::REG_FB_OFF_Y, 32'h0000_7FFF);
        reg_write(mmc_pkg::REG_FB_OFF_Z, 32'h1234_5A5A);
        reg_write(mmc_pkg::REG_FB_SCALE_X, 32'h0000_0000);
        reg_write(mmc_pkg::REG_FB_SCALE_Y, 32'hFFFF_FFFF);
        reg_write(mmc_pkg::REG_FB_SCALE_Z, 32'h0001_2345);
        reg_write(mmc_pkg::REG_MIN_RADIUS, 32'hFFFF_8000);
        send_item(mk_item(-32768, -32768, -32768, 1'b1, 1'b0));
        send_item(mk_item(32767, 32767, 32767, 1'b1, 1'b1));
        settle();

        // enabled with radius zero: any spread counts
        reg_write(mmc_pkg::REG_CAL_ENABLE, 32'h0000_0001);
        send_item(mk_item(0, 0, 0, 1'b1, 1'b0));
        send_item(mk_item(1, 1, 1, 1'b1, 1'b1));
        send_item(mk_item(0, 0, 0, 1'b0, 1'b1));                  // trackers were cleared
        calm = 1'b1;                                               // long run, no idling
        random_phase(RAND_ITEMS);
        calm = 1'b0;
        settle();

        // largest radius: only a full span on every axis passes
        reg_write(mmc_pkg::REG_MIN_RADIUS, 32'hFFFF_7FFF);
        send_item(mk_item(-32768, -32768, -32768, 1'b1, 1'b0));
        send_item(mk_item(32767, 32767, 32767, 1'b1, 1'b1));
        send_item(mk_item(-32768, -32768, -32767, 1'b1, 1'b0));
        send_item(mk_item(32767, 32767, 32767, 1'b0, 1'b1));
        random_phase(40);
        settle();

        write_random_config();
        random_phase(RAND_ITEMS);
        settle();

        // receiver stalls for a long stretch while windows keep coming
        write_random_config();
        reg_write(mmc_pkg::REG_CAL_ENABLE, 32'h0000_0001);
        hold_req = 1'b1;
        random_phase(RAND_ITEMS);
        settle();

        write_random_config();
        random_phase(RAND_ITEMS);
        settle();

        reg_write(mmc_pkg::REG_CAL_ENABLE, 32'h0000_0001);
        reg_write(mmc_pkg::REG_MIN_RADIUS, 32'h0000_0002);
        random_phase(RAND_ITEMS);
        settle();

        while (calib_sb.expected_cal_q.size() != 0) begin
            calib_sb.report_mismatch("expected result never arrived");
            void'(calib_sb.expected_cal_q.pop_front());
        end

        $display("Covered %0d items over %0d register settings: %0d results, %0d calibrated,",
                 calib_sb.n_inputs, cfg_phases, calib_sb.n_results, calib_sb.n_calibrated);
        $display("  %0d fallback, %0d saturated scales, %0d mismatches.",
                 calib_sb.n_fallback, calib_sb.n_saturated, calib_sb.errors);
        if (calib_sb.errors == 0)
            $display("** mag_minmax_calibrator_top: PASSED **");
        else
            $display("** mag_minmax_calibrator_top: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/mmc_pkg.sv
hw/rtl/mmc_div.sv
hw/rtl/mmc_lane.sv
hw/rtl/mmc_merge.sv
hw/rtl/mag_minmax_calibrator_top.sv
tb/tb_mag_minmax_calibrator_top.sv
